FILE: rtl/mrfb_pkg.sv
// Package with the shared types, constants and CRC function of the Modbus frame builder.
`timescale 1ns / 1ps
package mrfb_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned IdxW     = $clog2(FrameLen);

  localparam logic [15:0] CrcInit     = 16'hFFFF;
  // Reflected form of the 0x8005 polynomial.
  localparam logic [15:0] CrcPolyRefl = 16'hA001;

  typedef struct packed {
    logic        kind;
    logic [7:0]  target_address;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] data_word;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } byte_t;

  // One byte into a reflected CRC-16. This is a fixed XOR network.
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPolyRefl;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/mrfb_if.sv
// Handshake channel interfaces for requests, frame bytes and configuration writes.
`timescale 1ns / 1ps
interface mrfb_req_if;
  logic          valid;
  logic          ready;
  mrfb_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrfb_byte_if;
  logic           valid;
  logic           ready;
  mrfb_pkg::byte_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/modbus_request_frame_builder.sv
// Top level of the Modbus-RTU style request frame builder with CRC-16 pipeline.
`timescale 1ns / 1ps
//
//   channel   direction  word                                   accepted when
//   in_req    in         kind, target, function, register, data valid && ready
//   out_byte  out        frame_byte, last                       valid && ready
//   cfg_wr    in         device_address (8 bits)                valid (ready is always high)
//
// A request passes three CRC stages, two frame bytes folded into the CRC per
// stage, and is then loaded into the frame serializer, which sends one word per
// cycle while the output is ready; a new request can be accepted every cycle
// until the stages fill. The sustained rate is set by the one-byte-wide output.
// The first byte is offered once the request has passed stages 1, 2 and 3 and
// been loaded into the serializer. Reset is synchronous and active low and sets
// the device address to 1. A stall on the output holds the serializer and the
// stages behind it; nothing is dropped or repeated.
module modbus_request_frame_builder (
  input  logic              clk,
  input  logic              rst_n,
  mrfb_req_if.sink          in_req,
  mrfb_byte_if.source       out_byte,
  mrfb_cfg_if.sink          cfg_wr
);

  // Configuration register.
  logic [7:0] dev_addr_r;

  // Pipeline stage registers: the six frame bytes and the running CRC.
  logic        s1_v_r, s2_v_r, s3_v_r;
  logic [7:0]  s1_bytes_r [6];
  logic [7:0]  s2_bytes_r [6];
  logic [7:0]  s3_bytes_r [6];
  logic [15:0] s1_crc_r, s2_crc_r, s3_crc_r;

  // Serializer holding one complete frame.
  logic                       ser_v_r;
  logic [7:0]                 frame_r [mrfb_pkg::FrameLen];
  logic [mrfb_pkg::IdxW-1:0]  idx_r;

  logic       last_byte;
  logic       ser_free;
  logic       rdy1, rdy2, rdy3;
  logic       in_fire;
  logic [7:0] stn_byte;

  // The serializer takes a new frame when empty or when its last word leaves.
  assign last_byte = (idx_r == mrfb_pkg::IdxW'(mrfb_pkg::FrameLen - 1));
  assign ser_free  = !ser_v_r || (out_byte.ready && last_byte);

  // Each stage advances when it is empty or the stage after it moves.
  assign rdy3 = !s3_v_r || ser_free;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  assign in_req.ready = rdy1;
  assign in_fire      = in_req.valid && rdy1;
  assign cfg_wr.ready = 1'b1;

  assign stn_byte = in_req.data.kind ? in_req.data.target_address : dev_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd1;
    end else if (cfg_wr.valid) begin
      dev_addr_r <= cfg_wr.data;
    end
  end

  // Stage 1: build the frame bytes and fold in the station and function bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_req.valid;
    end
    if (in_fire) begin
      s1_bytes_r[0] <= stn_byte;
      s1_bytes_r[1] <= in_req.data.function_code;
      s1_bytes_r[2] <= in_req.data.register_address[7:0];
      s1_bytes_r[3] <= in_req.data.register_address[15:8];
      s1_bytes_r[4] <= in_req.data.data_word[7:0];
      s1_bytes_r[5] <= in_req.data.data_word[15:8];
      s1_crc_r <= mrfb_pkg::crc_add_byte(
                    mrfb_pkg::crc_add_byte(mrfb_pkg::CrcInit, stn_byte),
                    in_req.data.function_code);
    end
  end

  // Stage 2: register address bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
    if (rdy2 && s1_v_r) begin
      s2_bytes_r <= s1_bytes_r;
      s2_crc_r   <= mrfb_pkg::crc_add_byte(mrfb_pkg::crc_add_byte(s1_crc_r, s1_bytes_r[2]),
                                           s1_bytes_r[3]);
    end
  end

  // Stage 3: data word bytes; the CRC is final here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
    if (rdy3 && s2_v_r) begin
      s3_bytes_r <= s2_bytes_r;
      s3_crc_r   <= mrfb_pkg::crc_add_byte(mrfb_pkg::crc_add_byte(s2_crc_r, s2_bytes_r[4]),
                                           s2_bytes_r[5]);
    end
  end

  // Serializer: loads a whole frame, then steps through it one word per accept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      idx_r   <= '0;
    end else if (ser_free) begin
      ser_v_r <= s3_v_r;
      idx_r   <= '0;
    end else if (out_byte.ready) begin
      idx_r   <= idx_r + 1'b1;
    end
    if (ser_free && s3_v_r) begin
      for (int i = 0; i < 6; i++) begin
        frame_r[i] <= s3_bytes_r[i];
      end
      frame_r[6] <= s3_crc_r[7:0];
      frame_r[7] <= s3_crc_r[15:8];
    end
  end

  assign out_byte.valid           = ser_v_r;
  assign out_byte.data.frame_byte = frame_r[idx_r];
  assign out_byte.data.last       = last_byte;

`ifndef SYNTH
  // A stalled final stage keeps its CRC until the serializer takes it.
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !rdy3) |=> (s3_v_r && $stable(s3_crc_r)))
    else $error("stage 3 lost its frame during a stall");

  // A stalled output word keeps its position in the frame.
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_v_r && !out_byte.ready) |=> (ser_v_r && $stable(idx_r)))
    else $error("serializer moved while stalled");

  // After a non-final word leaves, the next word of the same frame follows.
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_v_r && out_byte.ready && !last_byte) |=> (ser_v_r && idx_r == $past(idx_r) + 1'b1))
    else $error("serializer skipped or repeated a word");
`endif

endmodule
